// ----- sv/kmpq_pkg.sv -----
// Keyed min priority queue: shared field widths, operation and action codes,
// and the scan token and apply command structs. No dependencies.
`default_nettype none

package kmpq_pkg;

	localparam int KEY_W = 16;
	localparam int VAL_W = 32;
	// position field covers the largest supported capacity (1024 entries)
	localparam int POS_W = 10;

	localparam logic [1:0] OP_PUT = 2'd0;
	localparam logic [1:0] OP_POP = 2'd1;
	localparam logic [1:0] OP_UPD = 2'd2;

	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_APPEND = 2'd2;
	localparam logic [1:0] ACT_SHIFT  = 2'd3;

	// token that walks the cell row, one cell per cycle
	typedef struct packed {
		logic                    live;
		logic                    hit;
		logic [POS_W-1:0]        hit_pos;
		logic                    have;
		logic [POS_W-1:0]        best_pos;
		logic [KEY_W-1:0]        best_key;
		logic signed [VAL_W-1:0] best_val;
	} token_t;

	// command broadcast to every cell in the same cycle
	typedef struct packed {
		logic [1:0]              kind;
		logic [POS_W-1:0]        pos;
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] val;
	} action_t;

endpackage

`default_nettype wire

// ----- sv/kmpq_cell.sv -----
// One storage cell of the keyed min priority queue: holds one key/value pair,
// updates the passing scan token and applies broadcast actions. Uses kmpq_pkg.
`default_nettype none

module kmpq_cell
	import kmpq_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire [CW-1:0]            count,
	input  wire [KEY_W-1:0]         key,
	input  token_t                  tok_in,
	output token_t                  tok_out,
	input  action_t                 act,
	input  wire [KEY_W-1:0]         nxt_key,
	input  wire signed [VAL_W-1:0]  nxt_val,
	output logic [KEY_W-1:0]        ent_key,
	output logic signed [VAL_W-1:0] ent_val
);

	localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);
	localparam logic [CW-1:0]    IDX_C = CW'(IDX);

	logic [KEY_W-1:0]        key_q;
	logic signed [VAL_W-1:0] val_q;
	token_t                  tok_q;
	token_t                  tok_d;
	logic                    occupied;

	assign occupied = (IDX_C < count);

	// fold this entry into the token: first key match, strict minimum
	always_comb begin
		tok_d = tok_in;
		if (tok_in.live && occupied) begin
			if (!tok_in.hit && (key_q == key)) begin
				tok_d.hit     = 1'b1;
				tok_d.hit_pos = IDX_P;
			end
			if (!tok_in.have || (val_q < tok_in.best_val)) begin
				tok_d.have     = 1'b1;
				tok_d.best_pos = IDX_P;
				tok_d.best_key = key_q;
				tok_d.best_val = val_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	// entry storage: overwrite, fill at tail, or close up from the neighbor
	always_ff @(posedge clk) begin
		case (act.kind)
			ACT_WRITE: begin
				if (act.pos == IDX_P) begin
					val_q <= act.val;
				end
			end
			ACT_APPEND: begin
				if (act.pos == IDX_P) begin
					key_q <= act.key;
					val_q <= act.val;
				end
			end
			ACT_SHIFT: begin
				if (IDX_P >= act.pos) begin
					key_q <= nxt_key;
					val_q <= nxt_val;
				end
			end
			default: begin
			end
		endcase
	end

	assign tok_out = tok_q;
	assign ent_key = key_q;
	assign ent_val = val_q;

endmodule

`default_nettype wire

// ----- sv/keyed_min_priority_queue_top.sv -----
// Keyed min priority queue top level: request sequencer over a row of
// kmpq_cell storage cells. Uses kmpq_pkg and kmpq_cell.
`default_nettype none

// Usage
//   Request channel: drive op, in_key and in_value and raise start; the
//   request is taken at a rising edge with start high and busy low.
//   op 0 inserts a pair (or overwrites the value of a present key), op 1
//   removes the entry with the smallest signed value (earliest on ties),
//   op 2 overwrites the value of a present key only; op 3 does nothing.
//   Result channel: done is high for exactly one cycle with out_key,
//   out_value, found, now_empty and overflow valid. The receiver cannot
//   stall; a result not taken in that cycle is gone.
//   Timing: a scan token enters the first cell the cycle after acceptance
//   and moves one cell per cycle through the whole row. In the cycle after
//   it leaves the row the action is broadcast to all cells, and in the
//   cycle after that done fires. A new request can be taken in the done
//   cycle but not before, so requests do not overlap: each one waits for
//   the walk of the token along the cell row.
//   Reset: arst_n clears the entry count and the sequencer; the queue is
//   empty afterwards and busy is low.

module keyed_min_priority_queue_top
	import kmpq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	output logic                    busy,
	input  wire [1:0]               op,
	input  wire [KEY_W-1:0]         in_key,
	input  wire signed [VAL_W-1:0]  in_value,
	output logic                    done,
	output logic [KEY_W-1:0]        out_key,
	output logic signed [VAL_W-1:0] out_value,
	output logic                    found,
	output logic                    now_empty,
	output logic                    overflow
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;

	logic [1:0]              state_q;
	logic [CW-1:0]           count_q;
	logic [1:0]              op_q;
	logic [KEY_W-1:0]        key_q;
	logic signed [VAL_W-1:0] val_q;
	logic                    seed_live_q;
	token_t                  seed;
	action_t                 act_q;
	logic                    done_q;
	logic [KEY_W-1:0]        out_key_q;
	logic signed [VAL_W-1:0] out_val_q;
	logic                    found_q;
	logic                    overflow_q;

	token_t                  tok [CAPACITY+1];
	logic [KEY_W-1:0]        ent_key [CAPACITY];
	logic signed [VAL_W-1:0] ent_val [CAPACITY];
	token_t                  tail;
	logic                    accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign tok[0] = seed;
	assign tail   = tok[CAPACITY];

	// Cell row: token flows from cell 0 to the tail; on a shift each cell from
	// the removed position on takes the next cell's pair, the last its own.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_W-1:0]        nk;
		logic signed [VAL_W-1:0] nv;
		if (i == CAPACITY - 1) begin : g_last
			assign nk = ent_key[i];
			assign nv = ent_val[i];
		end else begin : g_mid
			assign nk = ent_key[i+1];
			assign nv = ent_val[i+1];
		end
		kmpq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.count   (count_q),
			.key     (key_q),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.act     (act_q),
			.nxt_key (nk),
			.nxt_val (nv),
			.ent_key (ent_key[i]),
			.ent_val (ent_val[i])
		);
	end

	// Request payload: hold for the whole scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			key_q <= in_key;
			val_q <= in_value;
		end
	end

	// Seed token: empty handed, live for exactly one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_live_q <= 1'b0;
		end else begin
			seed_live_q <= accept;
		end
	end

	always_comb begin
		seed      = '0;
		seed.live = seed_live_q;
	end

	// Sequencer: wait for the token at the tail, decide, broadcast, report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			act_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			act_q.kind <= ACT_NONE;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tail.live) begin
						state_q   <= ST_APPLY;
						act_q.key <= key_q;
						act_q.val <= val_q;
						if (op_q == OP_POP) begin
							act_q.pos <= tail.best_pos;
						end else if (tail.hit) begin
							act_q.pos <= tail.hit_pos;
						end else begin
							act_q.pos <= POS_W'(count_q);
						end
						case (op_q)
							OP_PUT: begin
								if (tail.hit) begin
									act_q.kind <= ACT_WRITE;
								end else if (count_q < CAP_C) begin
									act_q.kind <= ACT_APPEND;
									count_q    <= count_q + CW'(1);
								end
							end
							OP_POP: begin
								if (tail.have) begin
									act_q.kind <= ACT_SHIFT;
									count_q    <= count_q - CW'(1);
								end
							end
							OP_UPD: begin
								if (tail.hit) begin
									act_q.kind <= ACT_WRITE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_APPLY: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result fields, captured as the token arrives.
	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && tail.live) begin
			found_q    <= (op_q == OP_POP) && tail.have;
			out_key_q  <= ((op_q == OP_POP) && tail.have) ? tail.best_key : '0;
			out_val_q  <= ((op_q == OP_POP) && tail.have) ? tail.best_val : '0;
			overflow_q <= (op_q == OP_PUT) && !tail.hit && (count_q == CAP_C);
		end
	end

	assign done      = done_q;
	assign out_key   = out_key_q;
	assign out_value = out_val_q;
	assign found     = found_q;
	assign overflow  = overflow_q;
	assign now_empty = (count_q == '0);

	// A result strobe only ever follows the broadcast cycle.
	a_done_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_APPLY))
		else $error("done without a preceding apply cycle");

	// The entry count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	// The scan token only reaches the tail while the sequencer waits for it.
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.live |-> (state_q == ST_SCAN))
		else $error("token at tail outside scan");

	// A dequeue result and an overflow never come together.
	a_found_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(found && overflow))
		else $error("found and overflow both set");

endmodule

`default_nettype wire
